// File: design/egcd_pkg.sv
// Shared types and constants for the extended GCD unit.
package egcd_pkg;

   localparam int DATA_W = 32;
   localparam int MAG_W  = DATA_W - 1;
   localparam int CNT_W  = $clog2(MAG_W);

   typedef struct packed {
      logic signed [DATA_W-1:0] operand_a;
      logic signed [DATA_W-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic        [MAG_W-1:0]  divisor;
      logic signed [DATA_W-1:0] coeff_a;
      logic signed [DATA_W-1:0] coeff_b;
      logic                     range_error;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic div_init;
      logic div_step;
      logic update;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic loop_done;
      logic div_last;
   } sts_type;

endpackage

// File: design/egcd_dpath.sv
// Datapath: operand magnitudes, remainders, Bezout coefficients and bit-serial divider.
module egcd_dpath (
   input  logic              clock,
   input  egcd_pkg::req_type req_data,
   input  egcd_pkg::cmd_type cmd,
   output egcd_pkg::sts_type sts,
   output egcd_pkg::rsp_type result
);

   localparam int DW = egcd_pkg::DATA_W;
   localparam int MW = egcd_pkg::MAG_W;
   localparam int CW = egcd_pkg::CNT_W;

   logic          a_neg_ff, a_neg_in;
   logic          b_neg_ff, b_neg_in;
   logic          err_ff, err_in;
   logic [MW-1:0] r0_ff, r0_in, r1_ff, r1_in;
   logic [MW-1:0] rem_ff, rem_in, dvd_ff, dvd_in;
   logic [DW-1:0] s0_ff, s0_in, s1_ff, s1_in;
   logic [DW-1:0] t0_ff, t0_in, t1_ff, t1_in;
   logic [DW-1:0] sacc_ff, sacc_in, tacc_ff, tacc_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic [DW-1:0] min_val;
   logic [DW-1:0] neg_a, neg_b;
   logic [MW:0]   trial, diff;
   logic          qbit;

   assign min_val = {1'b1, {(DW-1){1'b0}}};
   assign neg_a   = DW'(0) - req_data.operand_a;
   assign neg_b   = DW'(0) - req_data.operand_b;

   // one restoring-division step; quotient bit folds into the coefficient accumulators
   assign trial = {rem_ff, dvd_ff[MW-1]};
   assign diff  = trial - {1'b0, r1_ff};
   assign qbit  = trial >= {1'b0, r1_ff};

   always_comb begin
      a_neg_in = a_neg_ff;
      b_neg_in = b_neg_ff;
      err_in   = err_ff;
      r0_in    = r0_ff;
      r1_in    = r1_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      s0_in    = s0_ff;
      s1_in    = s1_ff;
      t0_in    = t0_ff;
      t1_in    = t1_ff;
      sacc_in  = sacc_ff;
      tacc_in  = tacc_ff;
      cnt_in   = cnt_ff;
      if (cmd.load) begin
         a_neg_in = req_data.operand_a[DW-1];
         b_neg_in = req_data.operand_b[DW-1];
         err_in   = (req_data.operand_a == min_val) || (req_data.operand_b == min_val);
         r0_in    = req_data.operand_a[DW-1] ? neg_a[MW-1:0] : req_data.operand_a[MW-1:0];
         r1_in    = req_data.operand_b[DW-1] ? neg_b[MW-1:0] : req_data.operand_b[MW-1:0];
         s0_in    = DW'(1);
         s1_in    = '0;
         t0_in    = '0;
         t1_in    = DW'(1);
      end
      if (cmd.div_init) begin
         rem_in  = '0;
         dvd_in  = r0_ff;
         sacc_in = '0;
         tacc_in = '0;
         cnt_in  = CW'(MW - 1);
      end
      if (cmd.div_step) begin
         rem_in  = qbit ? diff[MW-1:0] : trial[MW-1:0];
         dvd_in  = {dvd_ff[MW-2:0], 1'b0};
         sacc_in = {sacc_ff[DW-2:0], 1'b0} - (qbit ? s1_ff : '0);
         tacc_in = {tacc_ff[DW-2:0], 1'b0} - (qbit ? t1_ff : '0);
         cnt_in  = cnt_ff - CW'(1);
      end
      if (cmd.update) begin
         r0_in = r1_ff;
         r1_in = rem_ff;
         s0_in = s1_ff;
         s1_in = s0_ff + sacc_ff;
         t0_in = t1_ff;
         t1_in = t0_ff + tacc_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_neg_ff <= a_neg_in;
      b_neg_ff <= b_neg_in;
      err_ff   <= err_in;
      r0_ff    <= r0_in;
      r1_ff    <= r1_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      s0_ff    <= s0_in;
      s1_ff    <= s1_in;
      t0_ff    <= t0_in;
      t1_ff    <= t1_in;
      sacc_ff  <= sacc_in;
      tacc_ff  <= tacc_in;
      cnt_ff   <= cnt_in;
   end

   assign sts.loop_done = err_ff || (r1_ff == '0);
   assign sts.div_last  = (cnt_ff == '0);

   always_comb begin
      result.range_error = err_ff;
      result.divisor     = err_ff ? '0 : r0_ff;
      result.coeff_a     = err_ff ? '0 : (a_neg_ff ? DW'(0) - s0_ff : s0_ff);
      result.coeff_b     = err_ff ? '0 : (b_neg_ff ? DW'(0) - t0_ff : t0_ff);
   end

endmodule

// File: design/egcd_ctrl.sv
// Controller: sequences Euclid iterations and the bit-serial division steps.
module egcd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              out_free,
   output logic              out_load,
   input  egcd_pkg::sts_type sts,
   output egcd_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_TEST = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_UPD  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (sts.loop_done) begin
               state_in = ST_FIN;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            state_in   = ST_TEST;
         end
         ST_FIN: begin
            // hold until the output register can take the result
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/extended_gcd_unit.sv
// Top level of the extended GCD unit: controller, datapath and result register.
// Each item runs the extended Euclidean algorithm on |operand_a| and |operand_b| one item at a
// time. Every Euclid iteration is one loop test, a one-bit-per-cycle restoring divider that also
// accumulates both coefficient updates, and one register update. An item takes at most 45
// iterations for 31-bit magnitudes, none when operand_b is zero or an operand is out of range,
// and one when only operand_a is zero. The result sits in an output register, so the next
// item is accepted while the previous result waits for transfer; a finished item holds until
// that register is free.
module extended_gcd_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  egcd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output egcd_pkg::rsp_type rsp_data
);

   egcd_pkg::cmd_type cmd;
   egcd_pkg::sts_type sts;
   egcd_pkg::rsp_type result;
   logic              out_free;
   logic              out_load;
   logic              rsp_valid_ff, rsp_valid_in;
   egcd_pkg::rsp_type rsp_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   egcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .out_free  (out_free),
      .out_load  (out_load),
      .sts       (sts),
      .cmd       (cmd)
   );

   egcd_dpath u_dpath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .result   (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: dv/extended_gcd_unit_tb.sv
// Self-checking testbench for the extended GCD unit: random and directed operand pairs.
`timescale 1ns / 100ps

module extended_gcd_unit_tb;

   localparam logic [egcd_pkg::DATA_W-1:0] MOST_NEG = {1'b1, {egcd_pkg::MAG_W{1'b0}}};
   localparam logic [egcd_pkg::DATA_W-1:0] MOST_POS = {1'b0, {egcd_pkg::MAG_W{1'b1}}};
   localparam int RANDOM_ITEMS = 400;
   localparam int SETTLE_CYCLES = 1600;
   localparam int MAX_PRINTED = 100;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   egcd_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   egcd_pkg::rsp_type rsp_data;

   egcd_pkg::req_type operand_backlog[$];
   egcd_pkg::rsp_type awaited_bezout[$];
   logic    req_taken = 1'b0;
   int      send_idle = 0;
   int      recv_idle = 0;
   int      error_count = 0;

   extended_gcd_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // gcd of the magnitudes plus Bezout coefficients, sign-adjusted per operand
   function automatic egcd_pkg::rsp_type bezout_of(egcd_pkg::req_type req);
      logic [egcd_pkg::DATA_W-1:0] a, b, r0, r1, s0, s1, t0, t1, q, nxt;
      egcd_pkg::rsp_type res;
      res = '0;
      a = req.operand_a;
      b = req.operand_b;
      if (a == MOST_NEG || b == MOST_NEG) begin
         res.range_error = 1'b1;
         return res;
      end
      r0 = a[egcd_pkg::DATA_W-1] ? -a : a;
      r1 = b[egcd_pkg::DATA_W-1] ? -b : b;
      s0 = 1; s1 = 0;
      t0 = 0; t1 = 1;
      // coefficients wrap at the word width; the final values fit
      while (r1 != 0) begin
         q = r0 / r1;
         nxt = r0 - q * r1; r0 = r1; r1 = nxt;
         nxt = s0 - q * s1; s0 = s1; s1 = nxt;
         nxt = t0 - q * t1; t0 = t1; t1 = nxt;
      end
      res.divisor = r0[egcd_pkg::MAG_W-1:0];
      res.coeff_a = a[egcd_pkg::DATA_W-1] ? -s0 : s0;
      res.coeff_b = b[egcd_pkg::DATA_W-1] ? -t0 : t0;
      return res;
   endfunction

   function automatic logic [egcd_pkg::DATA_W-1:0] fibonacci(int n);
      logic [egcd_pkg::DATA_W-1:0] f0, f1, nxt;
      f0 = 0; f1 = 1;
      for (int i = 0; i < n; i++) begin
         nxt = f0 + f1; f0 = f1; f1 = nxt;
      end
      return f0;
   endfunction

   function automatic logic [egcd_pkg::DATA_W-1:0] random_sign(
      logic [egcd_pkg::DATA_W-1:0] mag);
      return $urandom_range(1) ? -mag : mag;
   endfunction

   function automatic egcd_pkg::req_type draw_operands();
      egcd_pkg::req_type req;
      int kind, k;
      logic [egcd_pkg::DATA_W-1:0] g;
      kind = $urandom_range(99);
      if (kind < 35) begin
         req.operand_a = $urandom;
         req.operand_b = $urandom;
      end else if (kind < 55) begin
         // consecutive Fibonacci numbers drive the longest quotient chains
         k = $urandom_range(1, 45);
         req.operand_a = random_sign(fibonacci(k + 1));
         req.operand_b = random_sign(fibonacci(k));
         if ($urandom_range(1)) req = {req.operand_b, req.operand_a};
      end else if (kind < 75) begin
         g = $urandom_range(1, 65535);
         req.operand_a = random_sign(g * $urandom_range(0, 32767));
         req.operand_b = random_sign(g * $urandom_range(0, 32767));
      end else if (kind < 85) begin
         req.operand_a = random_sign($urandom_range(0, 20));
         req.operand_b = random_sign($urandom_range(0, 20));
      end else if (kind < 92) begin
         req.operand_a = $urandom;
         req.operand_b = 0;
         if ($urandom_range(1)) req = {req.operand_b, req.operand_a};
      end else if (kind < 96) begin
         req.operand_a = random_sign($urandom_range(1) ? MOST_POS : 1);
         req.operand_b = random_sign($urandom_range(1) ? MOST_POS : MOST_POS - 1);
      end else begin
         req.operand_a = $urandom_range(1) ? MOST_NEG : $urandom;
         req.operand_b = $urandom_range(1) ? MOST_NEG : $urandom;
         if (req.operand_a != MOST_NEG && req.operand_b != MOST_NEG)
            req.operand_b = MOST_NEG;
      end
      return req;
   endfunction

   task automatic queue_pair(logic [egcd_pkg::DATA_W-1:0] a, logic [egcd_pkg::DATA_W-1:0] b);
      operand_backlog.push_back({a, b});
   endtask

   task automatic flag_mismatch(string msg);
      if (error_count < MAX_PRINTED) $display("ERROR: %s", msg);
      error_count++;
   endtask

   // hold until every queued pair is sent and every result has come back
   task automatic drain();
      while (operand_backlog.size() != 0 || req_valid || awaited_bezout.size() != 0)
         @(posedge clock);
   endtask

   always @(negedge clock) begin : drive
      logic launch;
      if (!reset && (!req_valid || req_taken)) begin
         launch = operand_backlog.size() != 0 && $urandom_range(99) >= send_idle;
         if (launch) req_data <= operand_backlog.pop_front();
         req_valid <= launch;
      end
      rsp_ready <= !reset && $urandom_range(99) >= recv_idle;
   end

   always @(posedge clock) begin : watch
      egcd_pkg::rsp_type want;
      req_taken <= req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) awaited_bezout.push_back(bezout_of(req_data));
         if (rsp_valid && rsp_ready) begin
            if (awaited_bezout.size() == 0) begin
               flag_mismatch($sformatf("unexpected result %h", rsp_data));
            end else begin
               want = awaited_bezout.pop_front();
               if (rsp_data.divisor !== want.divisor)
                  flag_mismatch($sformatf("divisor got %h want %h",
                                          rsp_data.divisor, want.divisor));
               if (rsp_data.coeff_a !== want.coeff_a)
                  flag_mismatch($sformatf("coeff_a got %h want %h",
                                          rsp_data.coeff_a, want.coeff_a));
               if (rsp_data.coeff_b !== want.coeff_b)
                  flag_mismatch($sformatf("coeff_b got %h want %h",
                                          rsp_data.coeff_b, want.coeff_b));
               if (rsp_data.range_error !== want.range_error)
                  flag_mismatch($sformatf("range_error got %b want %b",
                                          rsp_data.range_error, want.range_error));
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle = 32;
      recv_idle = 87;
      queue_pair(0, 0);
      queue_pair(5, 0);
      queue_pair(0, -7);
      queue_pair(-5, 0);
      queue_pair(MOST_NEG, 12);
      queue_pair(3, MOST_NEG);
      queue_pair(MOST_NEG, MOST_NEG);
      queue_pair(0, MOST_NEG);
      queue_pair(MOST_POS, MOST_POS);
      queue_pair(MOST_POS, MOST_POS - 1);
      queue_pair(MOST_POS, -MOST_POS);
      queue_pair(-MOST_POS, 1);
      queue_pair(1, 1);
      queue_pair(-1, -1);
      queue_pair(12, 18);
      queue_pair(-12, 18);
      queue_pair(12, -18);
      queue_pair(-240, -46);
      queue_pair(fibonacci(46), fibonacci(45));
      queue_pair(-fibonacci(45), fibonacci(46));
      queue_pair(32'hffff_ffff, 32'h0000_0001);
      queue_pair(32'h5555_5555, 32'h2aaa_aaaa);
      for (int i = 0; i < RANDOM_ITEMS / 3; i++) operand_backlog.push_back(draw_operands());
      drain();

      send_idle = 87;
      recv_idle = 32;
      for (int i = 0; i < RANDOM_ITEMS / 3; i++) operand_backlog.push_back(draw_operands());
      drain();

      send_idle = 0;
      recv_idle = 0;
      for (int i = 0; i < RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3); i++)
         operand_backlog.push_back(draw_operands());
      drain();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
